// File: hw/rtl/ballistic_launch_angle_unit_assert.svh
// Assertion macros shared by the launch angle unit.
`ifndef BALLISTIC_LAUNCH_ANGLE_UNIT_ASSERT_SVH
`define BALLISTIC_LAUNCH_ANGLE_UNIT_ASSERT_SVH
// Same-cycle implication check.
`define BLAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blau: same-cycle check failed");
// Next-cycle implication check.
`define BLAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blau: next-cycle check failed");
`endif

// File: hw/rtl/blau_pkg.sv
// Shared constants, types and the arctangent table of the launch angle unit.
`default_nettype none
package blau_pkg;
    localparam int unsigned FRACTION_BITS = 8;
    localparam int unsigned CORDIC_STEPS  = 24;
    localparam int unsigned ANGLE_BITS    = 24;

    // atan(2^-i) in degrees, Q.24
    localparam logic [31:0] ATAN_DEG [CORDIC_STEPS] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    typedef struct packed {
        logic [35:0] v2x5;
        logic [63:0] den;
        logic        unreach;
        logic        dzero;
        logic        hzero;
        logic        hneg;
    } t_side;
endpackage
`default_nettype wire

// File: hw/rtl/blau_item_if.sv
// Input channel: one targeting query per item.
`default_nettype none
interface blau_item_if;
    logic               valid;
    logic               ready;
    logic        [23:0] target_distance;
    logic signed [23:0] target_height;
    modport source (output valid, output target_distance, output target_height, input ready);
    modport sink (input valid, input target_distance, input target_height, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/blau_result_if.sv
// Output channel: one launch angle per item.
`default_nettype none
interface blau_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] launch_angle;
    logic               reachable;
    modport source (output valid, output launch_angle, output reachable, input ready);
    modport sink (input valid, input launch_angle, input reachable, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/blau_front.sv
// Product stages and discriminant of the launch angle unit.
`default_nettype none
module blau_front #(
    parameter int unsigned F  = blau_pkg::FRACTION_BITS,
    parameter int unsigned QW = 2 * F + 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic        [15:0] i_speed,
    input  wire logic        [23:0] i_dist,
    input  wire logic signed [23:0] i_height,
    output logic                    o_valid,
    output logic [QW-1:0]           o_q,
    output blau_pkg::t_side         o_side
);
    logic        r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic [31:0] r1_v2, r2_v2;
    logic [47:0] r1_d2;
    logic [23:0] r1_hmag, r1_d, r2_d;
    logic        r1_hneg, r1_dz, r1_hz, r2_hneg, r2_dz, r2_hz;
    logic [63:0] r2_v4;
    logic [59:0] r2_d2k, r3_d2k;
    logic [55:0] r2_hv;
    logic [68:0] r3_p25;
    logic [64:0] r3_hv490;
    logic [QW-1:0] r4_pos, r4_neg, r5_q;
    blau_pkg::t_side r3_side, r4_side, r5_side, n5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_comb begin
        n5_side = r4_side;
        n5_side.unreach = (r4_pos < r4_neg);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_v2   <= 32'(i_speed) * 32'(i_speed);
            r1_d2   <= 48'(i_dist) * 48'(i_dist);
            r1_hmag <= i_height[23] ? 24'(-i_height) : 24'(i_height);
            r1_hneg <= i_height[23];
            r1_dz   <= (i_dist == 24'd0);
            r1_hz   <= (i_height == 24'sd0);
            r1_d    <= i_dist;

            r2_v4   <= 64'(r1_v2) * 64'(r1_v2);
            r2_d2k  <= 60'(r1_d2) * 60'd2401;
            r2_hv   <= 56'(r1_hmag) * 56'(r1_v2);
            r2_v2   <= r1_v2;
            r2_d    <= r1_d;
            r2_hneg <= r1_hneg;
            r2_dz   <= r1_dz;
            r2_hz   <= r1_hz;

            r3_p25           <= 69'(r2_v4) * 69'd25;
            r3_hv490         <= 65'(r2_hv) * 65'd490;
            r3_d2k           <= r2_d2k;
            r3_side.v2x5     <= 36'(r2_v2) * 36'd5;
            r3_side.den      <= (64'(r2_d) * 64'd49) << F;
            r3_side.unreach  <= 1'b0;
            r3_side.dzero    <= r2_dz;
            r3_side.hzero    <= r2_hz;
            r3_side.hneg     <= r2_hneg;

            // height term adds to whichever side keeps it non-negative
            r4_pos  <= QW'(r3_p25) + (r3_side.hneg ? (QW'(r3_hv490) << F) : '0);
            r4_neg  <= (QW'(r3_d2k) << (2 * F))
                     + (r3_side.hneg ? '0 : (QW'(r3_hv490) << F));
            r4_side <= r3_side;

            r5_q    <= r4_pos - r4_neg;
            r5_side <= n5_side;
        end
    end

    assign o_valid = r5_valid;
    assign o_q     = r5_q;
    assign o_side  = r5_side;
endmodule
`default_nettype wire

// File: hw/rtl/blau_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module blau_sqrt #(
    parameter int unsigned QW = 80,
    parameter int unsigned RW = QW / 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [QW-1:0]  i_q,
    input  blau_pkg::t_side     i_side,
    output logic                o_valid,
    output logic [RW-1:0]       o_root,
    output blau_pkg::t_side     o_side
);
    logic [RW+3:0]   w_rem  [RW+1];
    logic [RW-1:0]   w_root [RW+1];
    logic [QW-1:0]   w_rest [RW+1];
    logic            w_val  [RW+1];
    blau_pkg::t_side w_side [RW+1];

    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_rest[0] = i_q;
    assign w_val[0]  = i_valid;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+3:0]   c_sh, c_trial;
        logic [RW+3:0]   r_rem;
        logic [RW-1:0]   r_root;
        logic [QW-1:0]   r_rest;
        logic            r_val;
        blau_pkg::t_side r_side;

        assign c_sh    = {w_rem[k][RW+1:0], w_rest[k][QW-1:QW-2]};
        assign c_trial = {2'b00, w_root[k], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val <= 1'b0;
            end else if (i_en) begin
                r_val <= w_val[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (c_sh >= c_trial) begin
                    r_rem  <= c_sh - c_trial;
                    r_root <= {w_root[k][RW-2:0], 1'b1};
                end else begin
                    r_rem  <= c_sh;
                    r_root <= {w_root[k][RW-2:0], 1'b0};
                end
                r_rest <= w_rest[k] << 2;
                r_side <= w_side[k];
            end
        end

        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_rest[k+1] = r_rest;
        assign w_val[k+1]  = r_val;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_val[RW];
    assign o_root  = w_root[RW];
    assign o_side  = w_side[RW];
endmodule
`default_nettype wire

// File: hw/rtl/blau_cordic.sv
// Numerator, normalize, CORDIC vectoring and rounding of the angle.
`default_nettype none
module blau_cordic #(
    parameter int unsigned F  = blau_pkg::FRACTION_BITS,
    parameter int unsigned RW = 40
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [RW-1:0]  i_root,
    input  blau_pkg::t_side     i_side,
    output logic                o_valid,
    output logic signed [15:0]  o_angle,
    output blau_pkg::t_side     o_side
);
    localparam int unsigned NS   = 6;
    localparam int unsigned NC   = blau_pkg::CORDIC_STEPS;
    localparam int unsigned SH   = blau_pkg::ANGLE_BITS - F;
    localparam logic signed [95:0] LIM  = 96'sd1 <<< 59;
    localparam logic [33:0]        HALF = 34'd1 << (SH - 1);

    // numerator stage
    logic               r_a_val;
    logic signed [63:0] r_a_x, r_a_y;
    blau_pkg::t_side    r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_val <= 1'b0;
        end else if (i_en) begin
            r_a_val <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_x    <= $signed(i_side.den);
            r_a_y    <= $signed(64'(i_side.v2x5)) - $signed(64'(i_root));
            r_a_side <= i_side;
        end
    end

    // greedy shift search: largest shift that keeps both below the limit
    logic signed [63:0] w_nx  [NS+1];
    logic signed [63:0] w_ny  [NS+1];
    logic               w_nc0 [NS+1];
    logic               w_nv  [NS+1];
    blau_pkg::t_side    w_ns  [NS+1];

    assign w_nx[0]  = r_a_x;
    assign w_ny[0]  = r_a_y;
    assign w_nv[0]  = r_a_val;
    assign w_ns[0]  = r_a_side;
    assign w_nc0[0] = (96'(r_a_x) < LIM) && (96'(r_a_y) < LIM) && (96'(r_a_y) > -LIM);

    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int unsigned S = 32 >> j;
        logic signed [95:0] c_tx, c_ty;
        logic               c_ok;
        logic signed [63:0] r_x, r_y;
        logic               r_c0, r_val;
        blau_pkg::t_side    r_side;

        assign c_tx = $signed(96'(w_nx[j])) <<< S;
        assign c_ty = $signed({{32{w_ny[j][63]}}, w_ny[j]}) <<< S;
        assign c_ok = w_nc0[j] && (c_tx < LIM) && (c_ty < LIM) && (c_ty > -LIM);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val <= 1'b0;
            end else if (i_en) begin
                r_val <= w_nv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= c_ok ? c_tx[63:0] : w_nx[j];
                r_y    <= c_ok ? c_ty[63:0] : w_ny[j];
                r_c0   <= w_nc0[j];
                r_side <= w_ns[j];
            end
        end

        assign w_nx[j+1]  = r_x;
        assign w_ny[j+1]  = r_y;
        assign w_nc0[j+1] = r_c0;
        assign w_nv[j+1]  = r_val;
        assign w_ns[j+1]  = r_side;
    end

    // one more doubling takes the pair just past the limit
    logic signed [63:0] w_cx [NC+1];
    logic signed [63:0] w_cy [NC+1];
    logic signed [32:0] w_cz [NC+1];
    logic               w_cv [NC+1];
    blau_pkg::t_side    w_cs [NC+1];
    logic               r_f_val;
    logic signed [63:0] r_f_x, r_f_y;
    blau_pkg::t_side    r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_val <= 1'b0;
        end else if (i_en) begin
            r_f_val <= w_nv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_x    <= w_nc0[NS] ? (w_nx[NS] <<< 1) : w_nx[NS];
            r_f_y    <= w_nc0[NS] ? (w_ny[NS] <<< 1) : w_ny[NS];
            r_f_side <= w_ns[NS];
        end
    end

    assign w_cx[0] = r_f_x;
    assign w_cy[0] = r_f_y;
    assign w_cz[0] = '0;
    assign w_cv[0] = r_f_val;
    assign w_cs[0] = r_f_side;

    for (genvar i = 0; i < NC; i++) begin : g_rot
        logic signed [63:0] r_x, r_y;
        logic signed [32:0] r_z;
        logic               r_val;
        blau_pkg::t_side    r_side;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val <= 1'b0;
            end else if (i_en) begin
                r_val <= w_cv[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_cy[i][63]) begin
                    r_x <= w_cx[i] + (w_cy[i] >>> i);
                    r_y <= w_cy[i] - (w_cx[i] >>> i);
                    r_z <= w_cz[i] + $signed(33'(blau_pkg::ATAN_DEG[i]));
                end else begin
                    r_x <= w_cx[i] - (w_cy[i] >>> i);
                    r_y <= w_cy[i] + (w_cx[i] >>> i);
                    r_z <= w_cz[i] - $signed(33'(blau_pkg::ATAN_DEG[i]));
                end
                r_side <= w_cs[i];
            end
        end

        assign w_cx[i+1] = r_x;
        assign w_cy[i+1] = r_y;
        assign w_cz[i+1] = r_z;
        assign w_cv[i+1] = r_val;
        assign w_cs[i+1] = r_side;
    end

    // round halves away from zero, then clamp to 16 bits
    logic signed [33:0] c_zx, c_val;
    logic        [33:0] c_mag, c_rnd;
    logic signed [15:0] c_sat;
    logic               r_o_val;
    logic signed [15:0] r_o_angle;
    blau_pkg::t_side    r_o_side;

    always_comb begin
        c_zx  = {w_cz[NC][32], w_cz[NC]};
        c_mag = c_zx[33] ? 34'(-c_zx) : 34'(c_zx);
        c_rnd = (c_mag + HALF) >> SH;
        c_val = c_zx[33] ? -$signed(c_rnd) : $signed(c_rnd);
        if (c_val > 34'sd32767) begin
            c_sat = 16'sh7fff;
        end else if (c_val < -34'sd32768) begin
            c_sat = -16'sh8000;
        end else begin
            c_sat = c_val[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_val <= 1'b0;
        end else if (i_en) begin
            r_o_val <= w_cv[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_angle <= c_sat;
            r_o_side  <= w_cs[NC];
        end
    end

    assign o_valid = r_o_val;
    assign o_angle = r_o_angle;
    assign o_side  = r_o_side;
endmodule
`default_nettype wire

// File: hw/rtl/ballistic_launch_angle_unit.sv
// Path: product stages, then square root stages, then angle stages, then one
// output register.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset clears all valid bits and the launch speed register to zero.
`default_nettype none
`include "ballistic_launch_angle_unit_assert.svh"
module ballistic_launch_angle_unit #(
    parameter int unsigned FRACTION_BITS = blau_pkg::FRACTION_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    blau_item_if.sink        i_item,
    blau_result_if.source    o_result
);
    localparam int unsigned QW = 2 * FRACTION_BITS + 64;
    localparam int unsigned RW = QW / 2;
    localparam logic signed [31:0] RIGHT = 32'sd90 <<< FRACTION_BITS;
    localparam logic signed [15:0] RIGHT_SAT =
        (RIGHT > 32'sd32767) ? 16'sh7fff : RIGHT[15:0];
    localparam logic signed [15:0] LEFT_SAT =
        (-RIGHT < -32'sd32768) ? -16'sh8000 : 16'(-RIGHT);

    logic            w_en;
    logic [15:0]     r_launch_speed;
    logic            w_f_val, w_s_val, w_c_val;
    logic [QW-1:0]   w_q;
    logic [RW-1:0]   w_root;
    logic signed [15:0] w_c_angle, n_angle;
    blau_pkg::t_side w_f_side, w_s_side, w_c_side;
    logic            r_out_valid, r_reach;
    logic signed [15:0] r_angle;

    assign w_en = !r_out_valid || o_result.ready;
    assign i_item.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_launch_speed <= 16'd0;
        end else if (i_cfg_we) begin
            r_launch_speed <= i_cfg_wdata;
        end
    end

    blau_front #(.F(FRACTION_BITS), .QW(QW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_item.valid),
        .i_speed  (r_launch_speed),
        .i_dist   (i_item.target_distance),
        .i_height (i_item.target_height),
        .o_valid  (w_f_val),
        .o_q      (w_q),
        .o_side   (w_f_side)
    );

    blau_sqrt #(.QW(QW), .RW(RW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_val),
        .i_q     (w_q),
        .i_side  (w_f_side),
        .o_valid (w_s_val),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    blau_cordic #(.F(FRACTION_BITS), .RW(RW)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_val),
        .i_root  (w_root),
        .i_side  (w_s_side),
        .o_valid (w_c_val),
        .o_angle (w_c_angle),
        .o_side  (w_c_side)
    );

    always_comb begin
        if (w_c_side.unreach) begin
            n_angle = '0;
        end else if (w_c_side.dzero) begin
            // straight up, straight down or level
            if (w_c_side.hzero) begin
                n_angle = '0;
            end else if (w_c_side.hneg) begin
                n_angle = LEFT_SAT;
            end else begin
                n_angle = RIGHT_SAT;
            end
        end else begin
            n_angle = w_c_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_c_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_angle <= n_angle;
            r_reach <= !w_c_side.unreach;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.launch_angle = r_angle;
    assign o_result.reachable    = r_reach;

    `BLAU_ASSERT_IMP(a_unreach_zero, i_clk, i_rst_n, r_out_valid && !r_reach, r_angle == 16'sd0)
    `BLAU_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_angle) && $stable(r_reach))
    `BLAU_ASSERT_NXT(a_drain, i_clk, i_rst_n, w_c_val && w_en, r_out_valid)
endmodule
`default_nettype wire

// File: test/tb_ballistic_launch_angle_unit.sv
// Self-checking testbench for the launch angle unit: queued stimulus, in-order angle check.
`default_nettype none
module tb_ballistic_launch_angle_unit;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 100;

    typedef enum logic [1:0] {
        STEP_QUERY,
        STEP_SET_SPEED,
        STEP_DRAIN
    } t_step_kind;

    typedef struct {
        t_step_kind         kind;
        logic        [23:0] distance;
        logic signed [23:0] height;
        logic        [15:0] speed;
        bit                 no_idle;
    } t_step;

    typedef struct {
        logic signed [15:0] angle;
        logic               reach;
    } t_aim;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    blau_item_if   item_ch();
    blau_result_if result_ch();

    ballistic_launch_angle_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    t_step       step_q[$];
    t_aim        aim_q[$];
    logic [15:0] speed_now;
    bit          query_taken;
    bit          tail_mode;
    int          send_gap;
    int          stall_left;
    int          settle_cnt;
    int          idle_cycles;
    int          mismatches;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Low-trajectory elevation for one target at the given muzzle speed.
    function automatic t_aim aim_for(logic [15:0] speed, logic [23:0] tgt_dist,
                                     logic signed [23:0] ht);
        logic [127:0] v2, pos, neg, hv, disc, trial;
        logic [63:0]  root;
        logic [23:0]  hmag;
        longint       x, y, z, dx, dy, ang;
        longint       lim;
        t_aim         res;
        v2   = 128'(speed) * 128'(speed);
        pos  = 128'd25 * v2 * v2;
        neg  = (128'd2401 * 128'(tgt_dist) * 128'(tgt_dist))
               << (2 * blau_pkg::FRACTION_BITS);
        hmag = ht[23] ? (~ht + 24'd1) : ht;
        hv   = (128'd490 * 128'(hmag) * v2) << blau_pkg::FRACTION_BITS;
        if (ht[23]) pos = pos + hv;
        else neg = neg + hv;
        if (pos < neg) begin
            res.angle = '0;
            res.reach = 1'b0;
            return res;
        end
        if (tgt_dist == 0) begin
            ang = (ht == 0) ? 0 : (ht[23] ? -(90 <<< blau_pkg::FRACTION_BITS)
                                          : (90 <<< blau_pkg::FRACTION_BITS));
        end else begin
            disc = pos - neg;
            root = '0;
            for (int b = 63; b >= 0; b--) begin
                trial = 128'(root | (64'd1 << b));
                if (trial * trial <= disc) root = trial[63:0];
            end
            y   = longint'(v2[63:0] * 64'd5) - longint'(root);
            x   = longint'(64'(tgt_dist) * 64'd49) <<< blau_pkg::FRACTION_BITS;
            lim = longint'(1) <<< 59;
            z   = 0;
            while (x < lim && y < lim && y > -lim) begin
                x = x * 2;
                y = y * 2;
            end
            for (int i = 0; i < blau_pkg::CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx; y = y - dy;
                    z = z + longint'({32'd0, blau_pkg::ATAN_DEG[i]});
                end else begin
                    x = x - dx; y = y + dy;
                    z = z - longint'({32'd0, blau_pkg::ATAN_DEG[i]});
                end
            end
            // round to output precision, halves away from zero
            if (z >= 0)
                ang = (z + (longint'(1) <<< (blau_pkg::ANGLE_BITS
                                             - blau_pkg::FRACTION_BITS - 1)))
                      >>> (blau_pkg::ANGLE_BITS - blau_pkg::FRACTION_BITS);
            else
                ang = -((-z + (longint'(1) <<< (blau_pkg::ANGLE_BITS
                                                - blau_pkg::FRACTION_BITS - 1)))
                        >>> (blau_pkg::ANGLE_BITS - blau_pkg::FRACTION_BITS));
        end
        if (ang > 32767) ang = 32767;
        if (ang < -32768) ang = -32768;
        res.angle = ang[15:0];
        res.reach = 1'b1;
        return res;
    endfunction

    task automatic add_query(logic [23:0] tgt_dist, logic signed [23:0] ht, bit no_idle);
        t_step s;
        s.kind = STEP_QUERY; s.distance = tgt_dist; s.height = ht; s.speed = '0;
        s.no_idle = no_idle;
        step_q.push_back(s);
    endtask

    task automatic add_mark(t_step_kind kind, logic [15:0] speed);
        t_step s;
        s.kind = kind; s.distance = '0; s.height = '0; s.speed = speed; s.no_idle = 1'b0;
        step_q.push_back(s);
    endtask

    // Random target: mostly field widths scaled into a plausible range, some full noise.
    task automatic add_random_query(bit no_idle);
        int unsigned w;
        logic [23:0] d, h;
        if ($urandom_range(0, 4) == 0) begin
            d = 24'($urandom);
            h = 24'($urandom);
        end else begin
            w = $urandom_range(1, 24);
            d = 24'($urandom & ((32'd1 << w) - 1));
            w = $urandom_range(1, 24);
            h = 24'($urandom & ((32'd1 << w) - 1));
            if (h[w-1]) h = h | ~((24'd1 << w) - 1);
        end
        add_query(d, h, no_idle);
    endtask

    // Driver: items and register writes change at the falling edge.
    always @(negedge i_clk) begin
        logic        nv;
        logic        nwe;
        logic [15:0] nwd;
        t_step       s;
        nv  = item_ch.valid;
        nwe = 1'b0;
        nwd = i_cfg_wdata;
        if (i_rst_n) begin
            if (nv && query_taken) nv = 1'b0;
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (step_q.size() > 0) begin
                    s = step_q[0];
                    case (s.kind)
                        STEP_QUERY: begin
                            void'(step_q.pop_front());
                            item_ch.target_distance <= s.distance;
                            item_ch.target_height   <= s.height;
                            nv = 1'b1;
                            tail_mode = s.no_idle;
                            if (!s.no_idle && $urandom_range(0, 9) == 0)
                                send_gap = $urandom_range(1, 12);
                        end
                        STEP_SET_SPEED: begin
                            if (aim_q.size() == 0 && settle_cnt >= SETTLE_CYCLES) begin
                                void'(step_q.pop_front());
                                nwe = 1'b1;
                                nwd = s.speed;
                            end
                        end
                        default: begin
                            if (aim_q.size() == 0) void'(step_q.pop_front());
                        end
                    endcase
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (!tail_mode && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 11);
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
        item_ch.valid <= nv;
        i_cfg_we      <= nwe;
        i_cfg_wdata   <= nwd;
    end

    // Monitor: predict on input accept, check on output accept.
    always @(posedge i_clk) begin
        t_aim want;
        bit   moved;
        moved = 1'b0;
        query_taken = item_ch.valid && item_ch.ready;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                speed_now = i_cfg_wdata;
                moved = 1'b1;
            end
            if (query_taken) begin
                aim_q.push_back(aim_for(speed_now, item_ch.target_distance,
                                        item_ch.target_height));
                moved = 1'b1;
            end
            if (result_ch.valid && result_ch.ready) begin
                moved = 1'b1;
                if (aim_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: angle %0d reachable %0d",
                                 result_ch.launch_angle, result_ch.reachable);
                end else begin
                    want = aim_q.pop_front();
                    if (result_ch.launch_angle !== want.angle ||
                        result_ch.reachable !== want.reach) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: angle exp %0d got %0d, reachable exp %0d got %0d",
                                     want.angle, result_ch.launch_angle,
                                     want.reach, result_ch.reachable);
                    end
                end
            end
            settle_cnt  = (aim_q.size() == 0 && !result_ch.valid) ? settle_cnt + 1 : 0;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int unsigned spd;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.target_distance = '0;
        item_ch.target_height = '0;
        result_ch.ready = 1'b0;
        speed_now = '0;
        query_taken = 1'b0;
        tail_mode = 1'b0;
        send_gap = 0;
        stall_left = 0;
        settle_cnt = 0;
        idle_cycles = 0;
        mismatches = 0;

        // zero speed right after reset: only a point-blank target is in reach
        add_query(24'd0, 24'sd0, 1'b0);
        add_query(24'd0, -24'sd256, 1'b0);
        add_query(24'd0, 24'sd256, 1'b0);
        add_query(24'd256, 24'sd0, 1'b0);
        // 50 m/s: straight up, straight down, level, extremes and edge of reach
        add_mark(STEP_SET_SPEED, 16'd12800);
        add_query(24'd0, 24'sd0, 1'b0);
        add_query(24'd0, 24'sd2560, 1'b0);
        add_query(24'd0, -24'sd2560, 1'b0);
        add_query(24'd0, 24'sh7fffff, 1'b0);
        add_query(24'd0, 24'sh800000, 1'b0);
        add_query(24'd1, 24'sd0, 1'b0);
        add_query(24'd25600, 24'sd0, 1'b0);
        add_query(24'd25600, 24'sd12800, 1'b0);
        add_query(24'd25600, -24'sd12800, 1'b0);
        add_query(24'd65306, 24'sd0, 1'b0);
        add_query(24'd65400, 24'sd0, 1'b0);
        add_query(24'hffffff, 24'sd0, 1'b0);
        add_query(24'hffffff, 24'sh800000, 1'b0);
        add_query(24'hffffff, 24'sh7fffff, 1'b0);
        add_query(24'd1, 24'sh800000, 1'b0);
        add_query(24'd1, 24'sh7fffff, 1'b0);
        add_mark(STEP_SET_SPEED, 16'hffff);
        add_query(24'hffffff, 24'sh800000, 1'b0);
        add_query(24'd1, -24'sd1, 1'b0);
        add_query(24'h5a5a5a, 24'sh2a5a5a, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: spd = 16'hffff;
                1: spd = 16'd0;
                2: spd = 16'd1;
                3: spd = 16'd25600;
                default: spd = $urandom_range(0, 65535);
            endcase
            add_mark(STEP_SET_SPEED, spd[15:0]);
            for (int n = 0; n < 100; n++) begin
                if (ph == 2 && n == 50) add_mark(STEP_DRAIN, '0);
                add_random_query(ph == 5);
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (step_q.size() == 0 && !item_ch.valid && aim_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && aim_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
